// File: hdl/jacobi_heat_stencil_pass_assert.svh
// Assertion macros shared by the stencil pass modules.
// Each macro expects clk and rst in scope.
`ifndef JACOBI_HEAT_STENCIL_PASS_ASSERT_SVH
`define JACOBI_HEAT_STENCIL_PASS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jhs_pkg.sv
`timescale 1ns / 1ps
package jhs_pkg;

  // Default grid size
  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;

  // Field widths
  localparam int HEAT_W = 16;
  localparam int SUM_W  = 28;
  localparam int THR_W  = 26;

  // Stop threshold after reset: 10.0 in Q8.8
  localparam logic [THR_W-1:0] THR_RESET = 26'd2560;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;

  typedef logic [HEAT_W-1:0]        heat_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [THR_W-1:0]         thresh_t;
  typedef logic [FIFO_AW-1:0]       ptr_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef struct packed {
    heat_t heat;
    logic  frame_end;
    logic  keep;
  } result_t;

  // Up to two results written per accepted request, res_a first
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } push_t;

endpackage

// File: hdl/jhs_cell.sv
`timescale 1ns / 1ps
module jhs_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  jhs_pkg::heat_t d_in,
  output jhs_pkg::heat_t d_out
);
  import jhs_pkg::*;

  heat_t value;

  // Take the neighbor's heat on every accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= d_in;
    end
  end

  assign d_out = value;

endmodule

// File: hdl/jhs_res_fifo.sv
`timescale 1ns / 1ps
`include "jacobi_heat_stencil_pass_assert.svh"
module jhs_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  jhs_pkg::push_t    push,
  input  logic              out_stall,
  output logic              out_valid,
  output jhs_pkg::result_t  out_res,
  output logic              no_room
);
  import jhs_pkg::*;

  result_t mem [FIFO_DEPTH];
  ptr_t    wr_ptr;
  ptr_t    rd_ptr;
  count_t  count;
  ptr_t    wr_b_ptr;
  logic    pop;
  count_t  n_push;

  assign pop      = out_valid && !out_stall;
  assign wr_b_ptr = wr_ptr + ptr_t'(push.push_a);
  assign n_push   = count_t'(push.push_a) + count_t'(push.push_b);

  // Store results in order
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem[wr_ptr] <= push.res_a;
    end
    if (push.push_b) begin
      mem[wr_b_ptr] <= push.res_b;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ptr_t'(n_push);
      rd_ptr <= rd_ptr + ptr_t'(pop);
      count  <= count + n_push - count_t'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  // Hold input while two more results might not fit
  assign no_room   = (count > count_t'(FIFO_DEPTH - 2));

  `JHS_ASSERT_NOW(a_count_max, 1'b1, count <= count_t'(FIFO_DEPTH), "result queue overflow")
  `JHS_ASSERT_NOW(a_push_order, push.push_b, push.push_a || count < count_t'(FIFO_DEPTH), "second result without space")
  `JHS_ASSERT_NEXT(a_two_push, push.push_a && push.push_b && !pop, count == $past(count) + count_t'(2), "double push not counted")

endmodule

// File: hdl/jacobi_heat_stencil_pass.sv
`timescale 1ns / 1ps
`include "jacobi_heat_stencil_pass_assert.svh"
// Jacobi five-point heat sweep over a raster-ordered grid of Q8.8 heats.
// Input channel: in_valid / in_stall carrying frame_start and cell_heat; a
// request is taken when in_valid is high and in_stall is low. frame_start
// marks the top-left cell and restarts position and change sum.
// Output channel: out_valid / out_stall carrying new_heat, frame_end and
// keep_running, one result per cell in raster order, lagging one grid row.
// Row 0 cells give no result; other cells give the result of the cell above;
// last-row cells also give their own border result right after it. keep_running
// is valid with frame_end: 1 when the summed interior change reached the
// threshold written through cfg_we / cfg_wdata.
// Each result is written into the result queue when the request that releases it
// is taken: the cell below it, or for last-row border results the cell itself.
// Throughput: one cell per cycle while in_stall is low; the line buffer is a shift
// chain of 2*GRID_COLS cells. Over the last row two results per cell leave through
// a one-result-per-cycle port, so in_stall holds the input back over that row.
// Reset clears positions, sum and the result queue and sets the threshold to
// 10.0; the line cells are not cleared. When the receiver stalls, the 4-entry
// result queue fills and in_stall rises once fewer than two slots are free.
module jacobi_heat_stencil_pass #(
  parameter int GRID_ROWS = jhs_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = jhs_pkg::GRID_COLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            frame_start,
  input  jhs_pkg::heat_t  cell_heat,
  output logic            out_valid,
  input  logic            out_stall,
  output jhs_pkg::heat_t  new_heat,
  output logic            frame_end,
  output logic            keep_running,
  input  logic            cfg_we,
  input  jhs_pkg::thresh_t cfg_wdata
);
  import jhs_pkg::*;

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int TAPS  = 2 * GRID_COLS;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic             acc;
  heat_t            tap [TAPS];
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic             last_row;
  logic             last_col;
  logic             has_above;
  logic             interior;
  heat_t            centre;
  heat_t            up;
  heat_t            left;
  heat_t            right;
  logic [HEAT_W+1:0] total;
  heat_t            res_int;
  heat_t            res_first;
  logic signed [HEAT_W:0] diff_next;
  logic signed [HEAT_W:0] diff_q;
  logic             pend;
  sum_t             change_sum;
  logic signed [SUM_W:0] wide;
  sum_t             sat;
  sum_t             sum_upd;
  logic             keep_now;
  thresh_t          stop_threshold;
  push_t            push;
  result_t          out_res;
  logic             no_room;

  assign acc = in_valid && !in_stall;

  // Line buffer: chain of cells, two rows long
  for (genvar g = 0; g < TAPS; g++) begin : g_chain
    if (g == 0) begin : g_head
      jhs_cell u_cell (.clk(clk), .shift_en(acc), .d_in(cell_heat), .d_out(tap[g]));
    end else begin : g_body
      jhs_cell u_cell (.clk(clk), .shift_en(acc), .d_in(tap[g-1]), .d_out(tap[g]));
    end
  end

  // Position of the incoming cell
  assign r_cur     = frame_start ? '0 : row_pos;
  assign c_cur     = frame_start ? '0 : col_pos;
  assign last_row  = (r_cur == ROW_LAST);
  assign last_col  = (c_cur == COL_LAST);
  assign has_above = (r_cur != '0);
  assign interior  = (r_cur > ROW_W'(1)) && (c_cur != '0) && !last_col;

  // Neighbors of the cell one row up
  assign right  = tap[GRID_COLS-2];
  assign centre = tap[GRID_COLS-1];
  assign left   = tap[GRID_COLS];
  assign up     = tap[TAPS-1];

  // Stencil average and change
  assign total     = {2'b00, up} + {2'b00, left} + {2'b00, right} + {2'b00, cell_heat};
  assign res_int   = total[HEAT_W+1:2];
  assign res_first = interior ? res_int : centre;
  assign diff_next = $signed({1'b0, res_int}) - $signed({1'b0, centre});

  // Saturating fold of the pending change
  assign wide = {change_sum[SUM_W-1], change_sum}
              + {{(SUM_W-HEAT_W){diff_q[HEAT_W]}}, diff_q};
  always_comb begin
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat = wide[SUM_W-1:0];
    end
  end
  assign sum_upd  = pend ? sat : change_sum;
  assign keep_now = !sum_upd[SUM_W-1] && (sum_upd[SUM_W-2:0] >= {1'b0, stop_threshold});

  // Advance position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : r_cur + ROW_W'(1);
      end else begin
        col_pos <= c_cur + COL_W'(1);
        row_pos <= r_cur;
      end
    end
  end

  // Accumulate interior change in the cycle after the stencil
  always_ff @(posedge clk) begin
    if (rst) begin
      change_sum <= '0;
      pend       <= 1'b0;
    end else begin
      if (acc && (frame_start || (last_row && last_col))) begin
        change_sum <= '0;
      end else begin
        change_sum <= sum_upd;
      end
      pend <= acc && interior;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      diff_q <= diff_next;
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= THR_RESET;
    end else if (cfg_we) begin
      stop_threshold <= cfg_wdata;
    end
  end

  // Results into the queue
  always_comb begin
    push.push_a          = acc && has_above;
    push.push_b          = acc && last_row;
    push.res_a.heat      = res_first;
    push.res_a.frame_end = 1'b0;
    push.res_a.keep      = 1'b0;
    push.res_b.heat      = cell_heat;
    push.res_b.frame_end = last_col;
    push.res_b.keep      = last_col && keep_now;
  end

  jhs_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .no_room   (no_room)
  );

  assign in_stall     = no_room;
  assign new_heat     = out_res.heat;
  assign frame_end    = out_res.frame_end;
  assign keep_running = out_res.keep;

  `JHS_ASSERT_NOW(a_keep_at_end, push.res_b.keep, push.res_b.frame_end, "keep without frame end")
  `JHS_ASSERT_NEXT(a_start_clears, acc && frame_start, change_sum == '0 && !pend, "sum not cleared at frame start")
  `JHS_ASSERT_NOW(a_pend_source, pend, $past(acc), "pending change without request")
  `JHS_ASSERT_NOW(a_last_row_pair, push.push_b, push.push_a, "border result without upper result")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import jhs_pkg::*;

  localparam int ROWS = GRID_ROWS_DEF;
  localparam int COLS = GRID_COLS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam int SUM_HI = (1 <<< (SUM_W - 1)) - 1;
  localparam int SUM_LO = -(1 <<< (SUM_W - 1));
  localparam int SETTLE_CYCLES = COLS + 8;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CELLS = 600;

  // Grid content used for one frame
  typedef enum int {
    KIND_FLAT,
    KIND_HOT_RIM,
    KIND_HOT_CORE,
    KIND_CHECKER,
    KIND_SMOOTH,
    KIND_NOISE
  } frame_kind_e;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  logic    frame_start;
  heat_t   cell_heat;
  logic    out_valid;
  logic    out_stall;
  heat_t   new_heat;
  logic    frame_end;
  logic    keep_running;
  logic    cfg_we;
  thresh_t cfg_wdata;

  // Predicted block state
  heat_t       line_above [COLS];
  heat_t       line_two_above [COLS];
  int unsigned cur_row;
  int unsigned cur_col;
  int          change_total;
  thresh_t     stop_thr;

  result_t pending_cells [$];
  result_t want;
  int      mismatch_count = 0;
  int      quiet_cycles;
  bit      send_idle_on = 1'b1;
  bit      recv_idle_on = 1'b1;
  bit      long_hold_req = 1'b0;

  jacobi_heat_stencil_pass #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_start(frame_start),
    .cell_heat(cell_heat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_heat(new_heat),
    .frame_end(frame_end),
    .keep_running(keep_running),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the sweep by one accepted cell and queue the results it releases
  task automatic sweep_cell(input logic start, input heat_t heat);
    int unsigned r;
    int unsigned c;
    heat_t mid;
    heat_t fresh;
    logic [HEAT_W+1:0] total;
    int change;
    result_t item;
    if (start) begin
      cur_row = 0;
      cur_col = 0;
      change_total = 0;
    end
    r = cur_row;
    c = cur_col;
    // result for the cell one row up
    if (r >= 1) begin
      mid = line_above[c];
      if (r == 1 || c == 0 || c == COLS - 1) begin
        fresh = mid;
      end else begin
        total = line_two_above[c] + line_two_above[c - 1] + line_above[c + 1] + heat;
        fresh = total[HEAT_W+1:2];
        change = change_total + int'(fresh) - int'(mid);
        if (change > SUM_HI) change = SUM_HI;
        if (change < SUM_LO) change = SUM_LO;
        change_total = change;
      end
      item.heat = fresh;
      item.frame_end = 1'b0;
      item.keep = 1'b0;
      pending_cells.push_back(item);
    end
    line_two_above[c] = line_above[c];
    line_above[c] = heat;
    // bottom row passes straight through, stop test on the last cell
    if (r == ROWS - 1) begin
      item.heat = heat;
      item.frame_end = (c == COLS - 1);
      item.keep = (c == COLS - 1) && (change_total >= int'(stop_thr));
      pending_cells.push_back(item);
    end
    cur_col = c + 1;
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= ROWS) begin
        cur_row = 0;
        change_total = 0;
      end
    end
  endtask

  // Offer one request, with an optional gap first, and wait for it to be taken
  task automatic send_cell(input logic start, input heat_t heat);
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_start <= start;
    cell_heat <= heat;
    do @(posedge clk); while (in_stall !== 1'b0);
    sweep_cell(start, heat);
  endtask

  function automatic heat_t pattern_heat(frame_kind_e kind, int r, int c, heat_t base);
    bit on_rim;
    heat_t v;
    on_rim = (r == 0) || (r == ROWS - 1) || (c == 0) || (c == COLS - 1);
    case (kind)
      KIND_FLAT:     v = base;
      KIND_HOT_RIM:  v = on_rim ? 16'hFFFF : 16'h0000;
      KIND_HOT_CORE: v = on_rim ? 16'h0000 : 16'hFFFF;
      KIND_CHECKER:  v = ((r + c) % 2 == 1) ? 16'hFFFF : 16'h0000;
      KIND_SMOOTH:   v = base + heat_t'($urandom_range(0, 1023));
      default:       v = heat_t'($urandom);
    endcase
    return v;
  endfunction

  // Stream cells of a frame in raster order, frame_start on the first if asked
  task automatic send_frame(input frame_kind_e kind, input bit with_start, input int cells);
    heat_t base;
    base = heat_t'($urandom);
    for (int i = 0; i < cells; i++) begin
      send_cell(with_start && i == 0, pattern_heat(kind, i / COLS, i % COLS, base));
    end
  endtask

  // Hold off new requests until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  task automatic set_stop_threshold(input thresh_t value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    stop_thr = value;
  endtask

  // Abandon a frame after some interior cells, then restart twice with one cell each
  task automatic test_restart();
    send_frame(KIND_NOISE, 1'b1, 2 * COLS + 3);
    send_frame(KIND_HOT_CORE, 1'b1, 1);
    send_frame(KIND_NOISE, 1'b1, 1);
  endtask

  // Write a new stop threshold while nothing is in flight
  task automatic test_threshold_write();
    set_stop_threshold(thresh_t'($urandom_range(0, 1 << 20)));
  endtask

  // Long receiver hold while requests keep coming, then a pause mid-frame
  task automatic test_back_pressure();
    long_hold_req = 1'b1;
    send_frame(KIND_NOISE, 1'b1, HOLD_CELLS);
    drain_results();
  endtask

  // Finish the frame at full rate on both sides
  task automatic test_full_rate();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    send_frame(KIND_NOISE, 1'b0, CELLS - HOLD_CELLS);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    frame_start <= 1'b0;
    cell_heat <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < COLS; i++) begin
      line_above[i] = '0;
      line_two_above[i] = '0;
    end
    cur_row = 0;
    cur_col = 0;
    change_total = 0;
    stop_thr = THR_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_restart();
    test_threshold_write();
    test_back_pressure();
    test_full_rate();

    // Wait out the last results, then a little longer for strays
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    int run_len;
    bit stall_now;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_now = 1'b1;
        run_len = LONG_HOLD;
      end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        stall_now = 1'b1;
        run_len = $urandom_range(1, 11);
      end else begin
        stall_now = 1'b0;
        run_len = $urandom_range(1, 16);
      end
      out_stall <= stall_now;
      repeat (run_len) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_cells.size() == 0) begin
        $error("new_heat: expected nothing, got %h", new_heat);
        mismatch_count++;
      end else begin
        want = pending_cells.pop_front();
        if (new_heat !== want.heat) begin
          $error("new_heat: expected %h, got %h", want.heat, new_heat);
          mismatch_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, frame_end);
          mismatch_count++;
        end
        if (keep_running !== want.keep) begin
          $error("keep_running: expected %b, got %b", want.keep, keep_running);
          mismatch_count++;
        end
      end
    end
  end

  // Drop the run when neither channel moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/jhs_pkg.sv
hdl/jhs_cell.sv
hdl/jhs_res_fifo.sv
hdl/jacobi_heat_stencil_pass.sv
bench/testbench.sv
